// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the decoder core modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that must hold in the same cycle as a trigger.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/core/lpid_pkg.sv =====
// Types, constants and helper functions of the palettized image decoder core.
package lpid_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PALETTE = 2'd1;
  localparam logic [1:0] KIND_PIXEL   = 2'd2;
  localparam logic [1:0] KIND_REJECT  = 2'd3;

  // Image formats.
  localparam logic [1:0] FMT_NIBBLE = 2'd0;
  localparam logic [1:0] FMT_BYTE   = 2'd1;
  localparam logic [1:0] FMT_RAW    = 2'd2;

  // Magic bytes.
  localparam logic [7:0] MAGIC_C     = 8'h43;
  localparam logic [7:0] MAGIC_D     = 8'h44;
  localparam logic [7:0] MAGIC_RAW_0 = 8'h00;
  localparam logic [7:0] MAGIC_RAW_1 = 8'h08;

  // Palette layout: slots start at 160; nibble files carry 5 entries, byte files 64.
  localparam logic [7:0] PAL_BASE        = 8'd160;
  localparam logic [5:0] PAL_LAST_NIBBLE = 6'd4;
  localparam logic [5:0] PAL_LAST_BYTE   = 6'd63;

  localparam logic [14:0] MAX_SIDE_RESET = 15'd4000;

  typedef enum logic [2:0] {
    PH_MAGIC1  = 3'd0,
    PH_MAGIC2  = 3'd1,
    PH_SIZE    = 3'd2,
    PH_PALETTE = 3'd3,
    PH_PIXELS  = 3'd4,
    PH_IDLE    = 3'd5
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  format;
    logic [14:0] width;
    logic [14:0] height;
    logic [7:0]  pal_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  pixel;
    logic [14:0] pix_x;
    logic [14:0] pix_y;
    logic        last_of_run;
  } out_word_t;

  // Scale a 0..63 component to 0..255: c*255/63 equals 4c + c/21, and c/21 is
  // found by three compares. Components above 63 saturate.
  function automatic logic [7:0] scale63(input logic [7:0] c);
    logic [1:0] q;
    begin
      if (c >= 8'd63)      q = 2'd3;
      else if (c >= 8'd42) q = 2'd2;
      else if (c >= 8'd21) q = 2'd1;
      else                 q = 2'd0;
      if (c > 8'd63) scale63 = 8'd255;
      else           scale63 = {c[5:0], 2'b00} + {6'd0, q};
    end
  endfunction

  // Nibbles 10 to 14 move to slots 160 to 164.
  function automatic logic [7:0] map_nibble(input logic [3:0] c);
    begin
      if (c >= 4'd10 && c < 4'd15) map_nibble = {4'd0, c} + 8'd150;
      else                         map_nibble = {4'd0, c};
    end
  endfunction

  function automatic logic [7:0] map_byte(input logic [7:0] c);
    begin
      if (c >= 8'h30) map_byte = c - 8'h20;
      else            map_byte = {4'd0, c[3:0]};
    end
  endfunction

  // A side is good when it is positive as a signed 16-bit value and within the limit.
  function automatic logic size_ok(input logic [15:0] s, input logic [14:0] max_side);
    begin
      size_ok = !s[15] && (s[14:0] != 15'd0) && (s[14:0] <= max_side);
    end
  endfunction

endpackage

// ===== rtl/core/lpid_parser.sv =====
// File parser: holds the decode state and turns one byte into up to two result words.
module lpid_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  lpid_pkg::in_word_t  in_word,
  input  logic [14:0]         max_side,
  output lpid_pkg::out_word_t res0,
  output lpid_pkg::out_word_t res1,
  output logic [1:0]          res_cnt
);
  import lpid_pkg::*;
  `include "assert_macros.svh"

  phase_t      phase, phase_next;
  logic [1:0]  image_format, image_format_next;
  logic [1:0]  comp, comp_next;
  logic [5:0]  entry, entry_next;
  logic [7:0]  saved_byte, saved_byte_next;
  logic [15:0] img_width, img_width_next;
  logic [15:0] img_height, img_height_next;
  logic [7:0]  color_part_r, color_part_r_next;
  logic [7:0]  color_part_g, color_part_g_next;
  logic [14:0] col_count, col_count_next;
  logic [14:0] row_count, row_count_next;

  // Next state and result words for the byte in the input register.
  always_comb begin
    phase_t      ph;
    logic [7:0]  b;
    logic [15:0] col_p1;
    logic [15:0] col_sum;
    logic [15:0] row_inc;
    logic [15:0] w16;
    logic [15:0] h16;
    logic [5:0]  pal_last;
    b = in_word.data_byte;
    ph = in_word.start_of_file ? PH_MAGIC1 : phase;
    image_format_next = in_word.start_of_file ? FMT_NIBBLE : image_format;
    comp_next         = in_word.start_of_file ? 2'd0 : comp;
    entry_next        = in_word.start_of_file ? 6'd0 : entry;
    col_count_next    = in_word.start_of_file ? 15'd0 : col_count;
    row_count_next    = in_word.start_of_file ? 15'd0 : row_count;
    phase_next        = ph;
    saved_byte_next   = saved_byte;
    img_width_next    = img_width;
    img_height_next   = img_height;
    color_part_r_next = color_part_r;
    color_part_g_next = color_part_g;
    res0    = '0;
    res1    = '0;
    res_cnt = 2'd0;
    w16 = {1'b0, img_width[14:0]};
    h16 = {1'b0, img_height[14:0]};
    col_p1  = {1'b0, col_count_next} + 16'd1;
    col_sum = 16'd0;
    row_inc = {1'b0, row_count_next} + 16'd1;
    pal_last = (image_format_next == FMT_NIBBLE) ? PAL_LAST_NIBBLE : PAL_LAST_BYTE;

    case (ph)
      PH_MAGIC1: begin
        image_format_next = FMT_NIBBLE;
        saved_byte_next   = b;
        phase_next        = PH_MAGIC2;
      end
      PH_MAGIC2: begin
        comp_next  = 2'd0;
        phase_next = PH_SIZE;
        if (saved_byte == MAGIC_C && b == MAGIC_C) begin
          image_format_next = FMT_NIBBLE;
        end else if (saved_byte == MAGIC_C && b == MAGIC_D) begin
          image_format_next = FMT_BYTE;
        end else if (saved_byte == MAGIC_RAW_0 && b == MAGIC_RAW_1) begin
          image_format_next = FMT_RAW;
        end else begin
          image_format_next = FMT_NIBBLE;
          comp_next    = comp;
          phase_next   = PH_IDLE;
          res0.kind    = KIND_REJECT;
          res0.format  = FMT_NIBBLE;
          res_cnt      = 2'd1;
        end
      end
      PH_SIZE: begin
        // Width low, width high, height low, height high.
        if (!comp_next[0])          saved_byte_next = b;
        else if (comp_next == 2'd1) img_width_next  = {b, saved_byte};
        else                        img_height_next = {b, saved_byte};
        comp_next = comp_next + 2'd1;
        if (comp_next == 2'd0) begin
          res0.format = image_format_next;
          res_cnt     = 2'd1;
          if (!size_ok(img_width_next, max_side) || !size_ok(img_height_next, max_side)) begin
            res0.kind  = KIND_REJECT;
            phase_next = PH_IDLE;
          end else begin
            res0.kind      = KIND_HEADER;
            res0.width     = img_width_next[14:0];
            res0.height    = img_height_next[14:0];
            entry_next     = 6'd0;
            col_count_next = 15'd0;
            row_count_next = 15'd0;
            phase_next     = (image_format_next == FMT_RAW) ? PH_PIXELS : PH_PALETTE;
          end
        end
      end
      PH_PALETTE: begin
        case (comp_next)
          2'd0: begin
            color_part_r_next = b;
            comp_next = 2'd1;
          end
          2'd1: begin
            color_part_g_next = b;
            comp_next = 2'd2;
          end
          default: begin
            res0.kind      = KIND_PALETTE;
            res0.format    = image_format_next;
            res0.pal_index = PAL_BASE + {2'd0, entry_next};
            res0.red       = scale63(color_part_r);
            res0.green     = scale63(color_part_g);
            res0.blue      = scale63(b);
            res_cnt        = 2'd1;
            comp_next      = 2'd0;
            if (entry_next == pal_last) begin
              entry_next = 6'd0;
              phase_next = PH_PIXELS;
            end else begin
              entry_next = entry_next + 6'd1;
            end
          end
        endcase
      end
      PH_PIXELS: begin
        res0.kind   = KIND_PIXEL;
        res0.format = image_format_next;
        res0.pix_x  = col_count_next;
        res0.pix_y  = row_count_next;
        res_cnt     = 2'd1;
        if (image_format_next == FMT_NIBBLE) begin
          // High nibble first; the low nibble past the row end is dropped.
          res0.pixel = map_nibble(b[7:4]);
          if (col_p1 < w16) begin
            res1.kind   = KIND_PIXEL;
            res1.format = image_format_next;
            res1.pixel  = map_nibble(b[3:0]);
            res1.pix_x  = col_p1[14:0];
            res1.pix_y  = row_count_next;
            res_cnt     = 2'd2;
          end
          col_sum = {1'b0, col_count_next} + 16'd2;
        end else begin
          res0.pixel = (image_format_next == FMT_BYTE) ? map_byte(b) : b;
          col_sum = col_p1;
        end
        if (col_sum >= w16) begin
          col_count_next = 15'd0;
          row_count_next = row_inc[14:0];
          if (row_inc >= h16) phase_next = PH_IDLE;
        end else begin
          col_count_next = col_sum[14:0];
        end
      end
      default: begin
      end
    endcase

    // Mark the last word caused by this byte.
    if (res_cnt == 2'd1) res0.last_of_run = 1'b1;
    if (res_cnt == 2'd2) res1.last_of_run = 1'b1;
  end

  // Decode state, updated when the byte moves on to the result buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_MAGIC1;
      image_format <= FMT_NIBBLE;
      comp         <= 2'd0;
      entry        <= 6'd0;
      saved_byte   <= 8'd0;
      img_width    <= 16'd0;
      img_height   <= 16'd0;
      color_part_r <= 8'd0;
      color_part_g <= 8'd0;
      col_count    <= 15'd0;
      row_count    <= 15'd0;
    end else if (advance) begin
      phase        <= phase_next;
      image_format <= image_format_next;
      comp         <= comp_next;
      entry        <= entry_next;
      saved_byte   <= saved_byte_next;
      img_width    <= img_width_next;
      img_height   <= img_height_next;
      color_part_r <= color_part_r_next;
      color_part_g <= color_part_g_next;
      col_count    <= col_count_next;
      row_count    <= row_count_next;
    end
  end

  // Only a nibble-packed pixel byte yields two words.
  `ASSERT_IMPLY(a_pair_only_nibble, res_cnt == 2'd2, (phase_next == PH_PIXELS || phase_next == PH_IDLE) && image_format == FMT_NIBBLE, "two results outside nibble pixels")
  // A finished file stays silent until a new file starts.
  `ASSERT_IMPLY(a_idle_silent, phase == PH_IDLE && !in_word.start_of_file, res_cnt == 2'd0, "result after end of file")

endmodule

// ===== rtl/core/lpid_outbuf.sv =====
// Two-entry result buffer that presents result words one at a time.
module lpid_outbuf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [1:0]          push_cnt,
  input  lpid_pkg::out_word_t push0,
  input  lpid_pkg::out_word_t push1,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output lpid_pkg::out_word_t out_word
);
  import lpid_pkg::*;
  `include "assert_macros.svh"

  out_word_t  entry0, entry1;
  logic [1:0] occ;
  logic       pop;

  // The buffer takes a new pair only when it will be empty after this cycle.
  assign out_valid = (occ != 2'd0);
  assign out_word  = entry0;
  assign pop       = out_valid && !out_stall;
  assign room      = (occ == 2'd0) || (occ == 2'd1 && pop);

  // Occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 2'd0;
    end else if (push) begin
      occ <= push_cnt;
    end else if (pop) begin
      occ <= occ - 2'd1;
    end
  end

  // Payload: a push fills from the front, a pop moves the second word up.
  always_ff @(posedge clk) begin
    if (push) begin
      entry0 <= push0;
      entry1 <= push1;
    end else if (pop) begin
      entry0 <= entry1;
    end
  end

  `ASSERT_ALWAYS(a_occ_bound, occ != 2'd3, "result buffer overfilled")
  `ASSERT_IMPLY(a_push_room, push, room, "push into a buffer without room")

endmodule

// ===== rtl/core/legacy_palettized_image_decoder_core.sv =====
// Top level of the palettized image decoder: input register, parser and result buffer.
// A byte is held in the input register, then moves with its result words into the result
// buffer, which offers them one at a time. Throughput: one byte per cycle while the buffer
// has room; a nibble byte with two pixels holds off the next while the single port drains them.
// Reset (rst, synchronous): parser waits for a magic, buffers empty, max_side is 4000.
module legacy_palettized_image_decoder_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  lpid_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output lpid_pkg::out_word_t out_word,
  input  logic                cfg_wr_en,
  input  logic [14:0]         cfg_wr_data
);
  import lpid_pkg::*;

  in_word_t    in_q;
  logic        in_q_valid;
  logic        fire;
  logic        room;
  logic        accept;
  logic [14:0] max_side;
  out_word_t   res0, res1;
  logic [1:0]  res_cnt;

  // The held word moves on when the result buffer can take a pair.
  assign fire     = in_q_valid && room;
  assign in_stall = in_q_valid && !fire;
  assign accept   = in_valid && !in_stall;

  // Size limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_side <= MAX_SIDE_RESET;
    end else if (cfg_wr_en) begin
      max_side <= cfg_wr_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (accept) begin
      in_q_valid <= 1'b1;
    end else if (fire) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_q <= in_word;
    end
  end

  lpid_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .advance  (fire),
    .in_word  (in_q),
    .max_side (max_side),
    .res0     (res0),
    .res1     (res1),
    .res_cnt  (res_cnt)
  );

  lpid_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .push_cnt  (res_cnt),
    .push0     (res0),
    .push1     (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

// ===== tb/lpid_decode_checker.sv =====
// Checker that predicts the decoder's result words from the accepted input words and compares them.
module lpid_decode_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  lpid_pkg::in_word_t  in_word,
  input  logic                out_valid,
  input  logic                out_stall,
  input  lpid_pkg::out_word_t out_word,
  input  logic                cfg_wr_en,
  input  logic [14:0]         cfg_wr_data,
  output int                  mismatch_count,
  output int                  results_owed
);
  import lpid_pkg::*;

  // Predicted parser state and the size limit currently in force.
  logic [14:0] side_limit;
  phase_t      parse_phase;
  logic [1:0]  file_fmt;
  logic [7:0]  field_idx;
  logic [7:0]  held_byte;
  logic [15:0] width_raw;
  logic [15:0] height_raw;
  logic [7:0]  red_part;
  logic [7:0]  green_part;
  int          column;
  int          row;

  // Result words still owed by the block, oldest first.
  out_word_t   expected_words[$];

  initial begin
    mismatch_count = 0;
    results_owed   = 0;
  end

  // A side is usable when it is positive as a signed 16-bit number and within the limit.
  function automatic bit side_fits(input logic [15:0] s);
    int v;
    v = s[15] ? int'(s) - 65536 : int'(s);
    return (v > 0) && (v <= int'(side_limit));
  endfunction

  // Components 0..63 stretch to 0..255; anything larger saturates.
  function automatic logic [7:0] stretch_component(input logic [7:0] c);
    int v;
    if (c > 8'd63) return 8'd255;
    v = (int'(c) * 255) / 63;
    return v[7:0];
  endfunction

  function automatic logic [7:0] nibble_slot(input logic [3:0] c);
    if (c >= 4'd10 && c <= 4'd14) return PAL_BASE + 8'(c - 4'd10);
    return {4'h0, c};
  endfunction

  function automatic logic [7:0] byte_slot(input logic [7:0] c);
    if (c >= 8'h30) return c - 8'h20;
    return {4'h0, c[3:0]};
  endfunction

  function automatic out_word_t blank_word(input logic [1:0] kind);
    out_word_t r;
    r = '0;
    r.kind = kind;
    r.format = file_fmt;
    return r;
  endfunction

  function automatic out_word_t pixel_word(input logic [7:0] v, input int x);
    out_word_t r;
    r = blank_word(KIND_PIXEL);
    r.pixel = v;
    r.pix_x = x[14:0];
    r.pix_y = row[14:0];
    return r;
  endfunction

  // Advance the predicted parser by one byte and queue the result words it causes.
  task automatic decode_word(input in_word_t iw);
    out_word_t  made [2];
    out_word_t  r;
    int         n;
    int         entries;
    int         w_px;
    int         h_px;
    bit         known;
    logic [7:0] b;
    b = iw.data_byte;
    n = 0;
    if (iw.start_of_file) begin
      parse_phase = PH_MAGIC1;
      file_fmt = FMT_NIBBLE;
      field_idx = '0;
      column = 0;
      row = 0;
    end
    case (parse_phase)
      PH_MAGIC1: begin
        file_fmt = FMT_NIBBLE;
        held_byte = b;
        parse_phase = PH_MAGIC2;
      end
      PH_MAGIC2: begin
        known = 1'b1;
        if (held_byte == MAGIC_C && b == MAGIC_C) file_fmt = FMT_NIBBLE;
        else if (held_byte == MAGIC_C && b == MAGIC_D) file_fmt = FMT_BYTE;
        else if (held_byte == MAGIC_RAW_0 && b == MAGIC_RAW_1) file_fmt = FMT_RAW;
        else known = 1'b0;
        if (!known) begin
          file_fmt = FMT_NIBBLE;
          made[n] = blank_word(KIND_REJECT);
          n++;
          parse_phase = PH_IDLE;
        end else begin
          field_idx = '0;
          parse_phase = PH_SIZE;
        end
      end
      PH_SIZE: begin
        // Width then height, each little-endian.
        if (!field_idx[0]) held_byte = b;
        else if (field_idx == 8'd1) width_raw = {b, held_byte};
        else height_raw = {b, held_byte};
        field_idx++;
        if (field_idx >= 8'd4) begin
          if (!side_fits(width_raw) || !side_fits(height_raw)) begin
            made[n] = blank_word(KIND_REJECT);
            n++;
            parse_phase = PH_IDLE;
          end else begin
            r = blank_word(KIND_HEADER);
            r.width = width_raw[14:0];
            r.height = height_raw[14:0];
            made[n] = r;
            n++;
            field_idx = '0;
            column = 0;
            row = 0;
            parse_phase = (file_fmt == FMT_RAW) ? PH_PIXELS : PH_PALETTE;
          end
        end
      end
      PH_PALETTE: begin
        // Every third byte completes a triple and writes the next slot.
        entries = (file_fmt == FMT_NIBBLE) ? 5 : 64;
        if (field_idx % 3 == 0) begin
          red_part = b;
        end else if (field_idx % 3 == 1) begin
          green_part = b;
        end else begin
          r = blank_word(KIND_PALETTE);
          r.pal_index = PAL_BASE + 8'(field_idx / 3);
          r.red = stretch_component(red_part);
          r.green = stretch_component(green_part);
          r.blue = stretch_component(b);
          made[n] = r;
          n++;
        end
        field_idx++;
        if (int'(field_idx) >= entries * 3) begin
          field_idx = '0;
          parse_phase = PH_PIXELS;
        end
      end
      PH_PIXELS: begin
        // Nibble rows are padded to whole bytes, so an odd width drops the last low nibble.
        w_px = int'(width_raw[14:0]);
        h_px = int'(height_raw[14:0]);
        if (file_fmt == FMT_NIBBLE) begin
          made[n] = pixel_word(nibble_slot(b[7:4]), column);
          n++;
          if (column + 1 < w_px) begin
            made[n] = pixel_word(nibble_slot(b[3:0]), column + 1);
            n++;
          end
          column += 2;
        end else begin
          made[n] = pixel_word((file_fmt == FMT_BYTE) ? byte_slot(b) : b, column);
          n++;
          column += 1;
        end
        if (column >= w_px) begin
          column = 0;
          row++;
          if (row >= h_px) parse_phase = PH_IDLE;
        end
      end
      default: ;
    endcase
    if (n > 0) begin
      r = made[n - 1];
      r.last_of_run = 1'b1;
      made[n - 1] = r;
    end
    for (int i = 0; i < n; i++) expected_words.push_back(made[i]);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare results first so that a word arriving with nothing owed is never hidden.
  always @(posedge clk) begin : watch
    out_word_t want;
    if (rst) begin
      side_limit = MAX_SIDE_RESET;
      parse_phase = PH_MAGIC1;
      file_fmt = FMT_NIBBLE;
      field_idx = '0;
      held_byte = '0;
      width_raw = '0;
      height_raw = '0;
      red_part = '0;
      green_part = '0;
      column = 0;
      row = 0;
      expected_words.delete();
    end else begin
      if (cfg_wr_en) side_limit = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("result word of kind %0d arrived with nothing owed", out_word.kind);
          mismatch_count++;
        end else begin
          want = expected_words.pop_front();
          compare_field("kind", want.kind, out_word.kind);
          compare_field("format", want.format, out_word.format);
          compare_field("width", want.width, out_word.width);
          compare_field("height", want.height, out_word.height);
          compare_field("pal_index", want.pal_index, out_word.pal_index);
          compare_field("red", want.red, out_word.red);
          compare_field("green", want.green, out_word.green);
          compare_field("blue", want.blue, out_word.blue);
          compare_field("pixel", want.pixel, out_word.pixel);
          compare_field("pix_x", want.pix_x, out_word.pix_x);
          compare_field("pix_y", want.pix_y, out_word.pix_y);
          compare_field("last_of_run", want.last_of_run, out_word.last_of_run);
        end
      end
      if (in_valid && !in_stall) decode_word(in_word);
    end
    results_owed = expected_words.size();
  end

endmodule

// ===== tb/tb_legacy_palettized_image_decoder_core.sv =====
// Testbench top: feeds image files into the decoder, varies the size limit and gives the verdict.
module tb_legacy_palettized_image_decoder_core;
  import lpid_pkg::*;

  localparam int ITEM_TARGET   = 1250;
  localparam int LIMIT_EVERY   = 250;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 800000;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_word;
  logic        cfg_wr_en = 1'b0;
  logic [14:0] cfg_wr_data = '0;

  int          mismatch_count;
  int          results_owed;
  int          drain_errors = 0;
  int          bytes_sent = 0;
  logic [14:0] side_limit = MAX_SIDE_RESET;
  bit          hold_out = 1'b0;
  bit          steady_feed = 1'b0;
  logic [7:0]  file_bytes[$];

  always #6 clk = ~clk;

  legacy_palettized_image_decoder_core dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  lpid_decode_checker decode_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_word        (in_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word       (out_word),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  // Mostly back-to-back bytes, with short gaps and the occasional long one.
  function automatic int pick_gap();
    int r;
    if (steady_feed) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  // Offer one word at the falling edge and hold it until the block takes it.
  task automatic send_word(input logic [7:0] b, input logic sof);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= '{data_byte: b, start_of_file: sof};
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++) send_word(file_bytes[i], i == 0);
    file_bytes.delete();
  endtask

  // Stop offering, let every owed result arrive, then give the parser time to settle.
  task automatic wait_drained();
    int n;
    n = 0;
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
      n++;
    end while (results_owed != 0 && n < DRAIN_LIMIT);
    if (results_owed != 0) begin
      $error("%0d result words never arrived", results_owed);
      drain_errors++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_side_limit(input logic [14:0] v);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    side_limit = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic add_size(input logic [15:0] w, input logic [15:0] h);
    file_bytes.push_back(w[7:0]);
    file_bytes.push_back(w[15:8]);
    file_bytes.push_back(h[7:0]);
    file_bytes.push_back(h[15:8]);
  endtask

  // One file: mostly well formed with random content, the rest bad sizes, bad magic or noise.
  task automatic build_random_file();
    int          r;
    int          w;
    int          h;
    int          wmax;
    int          hmax;
    int          entries;
    int          row_bytes;
    int          cut;
    logic [1:0]  fmt;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  dropped;
    logic [15:0] bad;
    wmax = (side_limit < 9) ? int'(side_limit) : 9;
    hmax = (side_limit < 4) ? int'(side_limit) : 4;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      r = $urandom_range(0, 99);
      fmt = (r < 45) ? FMT_NIBBLE : (r < 60) ? FMT_BYTE : FMT_RAW;
      case (fmt)
        FMT_NIBBLE: begin
          file_bytes.push_back(MAGIC_C);
          file_bytes.push_back(MAGIC_C);
        end
        FMT_BYTE: begin
          file_bytes.push_back(MAGIC_C);
          file_bytes.push_back(MAGIC_D);
        end
        default: begin
          file_bytes.push_back(MAGIC_RAW_0);
          file_bytes.push_back(MAGIC_RAW_1);
        end
      endcase
      w = $urandom_range(1, wmax);
      h = $urandom_range(1, hmax);
      if ($urandom_range(0, 9) == 0) w = $urandom_range(1, (side_limit < 40) ? side_limit : 40);
      if ($urandom_range(0, 99) < 15) begin
        // One side zero, negative, just over the limit or random.
        r = $urandom_range(0, 3);
        if (r == 0) bad = 16'd0;
        else if (r == 1) bad = 16'h8000 | 16'($urandom_range(0, 32767));
        else if (r == 2) bad = {1'b0, side_limit} + 16'd1;
        else bad = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 1) == 0) add_size(bad, 16'(h));
        else add_size(16'(w), bad);
      end else begin
        add_size(16'(w), 16'(h));
      end
      if (fmt != FMT_RAW) begin
        entries = (fmt == FMT_NIBBLE) ? 5 : 64;
        for (int i = 0; i < entries * 3; i++) begin
          r = $urandom_range(0, 99);
          if (r < 80) file_bytes.push_back(8'($urandom_range(0, 63)));
          else if (r < 90) file_bytes.push_back(($urandom_range(0, 1) == 0) ? 8'd0 : 8'd63);
          else file_bytes.push_back(8'($urandom_range(64, 255)));
        end
      end
      row_bytes = (fmt == FMT_NIBBLE) ? (w + 1) / 2 : w;
      for (int i = 0; i < row_bytes * h; i++) file_bytes.push_back(8'($urandom_range(0, 255)));
      // Some files break off early; some carry stray bytes after the end.
      if ($urandom_range(0, 7) == 0) begin
        cut = $urandom_range(1, file_bytes.size() - 1);
        while (file_bytes.size() > cut) dropped = file_bytes.pop_back();
      end else if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) file_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end else if (r < 90) begin
      r = $urandom_range(0, 2);
      b1 = (r == 0) ? MAGIC_C : (r == 1) ? MAGIC_RAW_0 : 8'($urandom_range(0, 255));
      do b2 = 8'($urandom_range(0, 255));
      while ((b1 == MAGIC_C && (b2 == MAGIC_C || b2 == MAGIC_D)) ||
             (b1 == MAGIC_RAW_0 && b2 == MAGIC_RAW_1));
      file_bytes.push_back(b1);
      file_bytes.push_back(b2);
      repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 8)) file_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Receiver: random stall bursts and free stretches, plus a long hold-off on request.
  initial begin : receiver
    int r;
    int len;
    logic s;
    forever begin
      if (hold_out) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_out = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          s = 1'b0;
          len = $urandom_range(1, 20);
        end else if (r < 93) begin
          s = 1'b1;
          len = $urandom_range(1, 3);
        end else if (r < 98) begin
          s = 1'b1;
          len = $urandom_range(5, 30);
        end else begin
          s = 1'b0;
          len = $urandom_range(60, 200);
        end
        out_stall <= s;
        repeat (len) begin
          @(negedge clk);
          if (hold_out) break;
        end
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int next_limit_change;
    int holds_done;
    int r;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Nibble file of odd width: palette extremes, remapped and dropped nibbles, a stray byte.
    file_bytes = '{MAGIC_C, MAGIC_C, 8'd3, 8'd0, 8'd1, 8'd0,
                   8'd0, 8'd63, 8'd64, 8'd255, 8'd21, 8'd42, 8'd20, 8'd62, 8'd1,
                   8'd63, 8'd0, 8'd255, 8'd41, 8'd22, 8'd43,
                   8'hAF, 8'hE5, MAGIC_C};
    send_file();
    // Unknown magic, then a byte that must be ignored.
    file_bytes = '{MAGIC_C, 8'h45, 8'h00};
    send_file();
    // Raw file whose width is negative.
    file_bytes = '{MAGIC_RAW_0, MAGIC_RAW_1, 8'h00, 8'h80, 8'h01, 8'h00};
    send_file();

    // Smallest limit: a 1x1 image passes, a width of two does not.
    set_side_limit(15'd1);
    file_bytes = '{MAGIC_RAW_0, MAGIC_RAW_1, 8'd1, 8'd0, 8'd1, 8'd0, 8'hFF};
    send_file();
    file_bytes = '{MAGIC_RAW_0, MAGIC_RAW_1, 8'd2, 8'd0, 8'd1, 8'd0};
    send_file();

    // Largest limit: full-size header, a few pixels, then the next file cuts in.
    set_side_limit(15'd32767);
    file_bytes = '{MAGIC_RAW_0, MAGIC_RAW_1, 8'hFF, 8'h7F, 8'hFF, 8'h7F, 8'h5A, 8'hA5, 8'h00};
    send_file();

    // Random files, with a new limit every so often.
    next_limit_change = bytes_sent + LIMIT_EVERY;
    holds_done = 0;
    while (bytes_sent < ITEM_TARGET) begin
      if (bytes_sent >= next_limit_change) begin
        r = $urandom_range(0, 99);
        if (r < 40) set_side_limit(15'($urandom_range(1, 12)));
        else if (r < 75) set_side_limit(15'($urandom_range(13, 32767)));
        else if (r < 88) set_side_limit(MAX_SIDE_RESET);
        else set_side_limit(15'd32767);
        next_limit_change += LIMIT_EVERY;
      end
      // Twice, the receiver holds off while the sender keeps going.
      if (holds_done < 2 && bytes_sent >= 500 * (holds_done + 1)) begin
        hold_out = 1'b1;
        holds_done++;
      end
      steady_feed = ($urandom_range(0, 4) == 0);
      build_random_file();
      send_file();
    end

    wait_drained();
    if (mismatch_count == 0 && drain_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
